// ===== rtl/pcorr_pkg.sv =====
package pcorr_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_PAIRS   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // fixed result field widths
    localparam int COEF_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // datapath widths
    localparam int MUL_W  = 32;             // shared multiplier operand width
    localparam int WORD_W = 2 * MUL_W;      // working word, sums taken mod 2^64

    // square root operand is normalized to at least 2^NORM_TOP
    localparam int NORM_TOP = 60;

    // quotient: at most INT_BITS integer bits (operand >= 2^60), FRAC_BITS fraction bits, Q4.15
    localparam int INT_BITS  = 4;
    localparam int FRAC_BITS = 15;
    localparam int DIV_STEPS = INT_BITS + FRAC_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // +1.0 in Q1.14
    localparam int Q_ONE = 16384;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

// ===== rtl/pcorr_mul.sv =====
// Shared unsigned multiplier, product registered.
module pcorr_mul
    import pcorr_pkg::*;
(
    input  logic               i_clk,
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    output logic [WORD_W-1:0]  o_p
);

    logic [WORD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= WORD_W'(i_a) * WORD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/pearson_correlation.sv =====
// Pearson correlation over a stream of (x, y) sample pairs.
//
// Input channel (i_valid / o_stall): one word carries a signed pair and a
// last-pair flag. While o_stall is high the block is busy and takes nothing.
// Output channel (o_valid / i_stall): one word per data set, emitted after
// the pair flagged last: r in signed Q1.14, a status code (ok, zero
// variance, too many pairs) and the number of pairs summed.
//
// Flow: every accepted pair keeps the block busy while its three products
// (x*y, x*x, y*y) run through the one shared 32x32 multiplier; a pair past
// the limit is dropped and not multiplied. After the last pair the block
// forms six 64-bit products, runs two normalize loops, two 32-step square
// roots, the divisor product and a 19-step restoring divide, the root and
// divide steps all going through one shared 65-bit subtractor. If that
// last pair was dropped its pair products are skipped; when a variance is
// zero the block goes from the check straight to the output step.
//
// Reset (synchronous, active low) clears the sums, the count, the overflow
// flag and the output valid. A stalled result sits in the output register;
// the block keeps taking pairs meanwhile and only waits, in its final step,
// if a new result is ready before the old one has been taken.
module pearson_correlation
    import pcorr_pkg::*;
#(
    parameter int MAX_PAIRS   = DEF_MAX_PAIRS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pair input
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_y_sample,
    input  logic                          i_last_pair,
    // result output
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COEF_W-1:0]      o_coefficient,
    output logic [STATUS_W-1:0]           o_status,
    output logic [COUNT_W-1:0]            o_pair_count
);

    // Sum widths follow from the sample width and set length.
    localparam int LOG_N  = $clog2(MAX_PAIRS);
    localparam int PAIRS_W = $clog2(MAX_PAIRS + 1);
    localparam int SUMX_W = SAMPLE_BITS + LOG_N;
    localparam int SUMP_W = 2 * SAMPLE_BITS + LOG_N;

    typedef enum logic [3:0] {
        S_IDLE,     // wait for a pair
        S_ACC,      // square / cross products of the pair
        S_PROD,     // num, vx, vy as 64-bit products
        S_CHECK,    // zero variance test, sign of num
        S_NORM,     // shift root operand up to >= 2^60, mag along with it
        S_SQRT,     // one root bit per cycle
        S_DMUL,     // d = sx * sy
        S_DIV,      // one quotient bit per cycle
        S_OUT       // round, clamp, hand over
    } t_state;

    t_state r_state;

    // running sums
    logic signed [SUMX_W-1:0]  r_sum_x, r_sum_y;
    logic signed [SUMP_W-1:0]  r_sum_xy, r_sum_xx, r_sum_yy;
    logic [PAIRS_W-1:0]        r_pairs;
    logic                      r_over;

    // latched pair
    logic [SAMPLE_BITS-1:0]    r_xa, r_ya;
    logic                      r_neg_xy;
    logic                      r_last;

    // sequencing
    logic [1:0]                r_c;
    logic [2:0]                r_j;
    logic [DCNT_W-1:0]         r_cnt;
    logic                      r_sel_y;

    // compute datapath
    logic [WORD_W-1:0]         r_acc, r_t;
    logic [WORD_W-1:0]         r_num, r_vx, r_vy;
    logic [WORD_W-1:0]         r_mag;
    logic                      r_neg;
    logic                      r_zero;
    logic [WORD_W-1:0]         r_v, r_res, r_bit;
    logic [MUL_W-1:0]          r_sx, r_sy;
    logic [WORD_W-1:0]         r_d, r_rem;
    logic [DIV_STEPS-1:0]      r_q, r_nbits;

    // output register
    logic                      r_o_valid;
    logic signed [COEF_W-1:0]  r_coef;
    logic [STATUS_W-1:0]       r_status;
    logic [COUNT_W-1:0]        r_count;

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    logic                      in_take;
    logic [SAMPLE_BITS-1:0]    x_abs, y_abs;

    assign o_stall = (r_state != S_IDLE);
    assign in_take = i_valid && !o_stall;

    assign x_abs = i_x_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_x_sample)
                                             : SAMPLE_BITS'(i_x_sample);
    assign y_abs = i_y_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_y_sample)
                                             : SAMPLE_BITS'(i_y_sample);

    // ------------------------------------------------------------------
    // Shared multiplier and its operand select
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] op_a, op_b;       // 64-bit operands of S_PROD
    logic [SUMP_W-1:0] pp;               // pair product, truncated to sum width
    logic [WORD_W-1:0] prod_full;        // finished 64-bit product

    always_comb begin
        case (r_j)
            3'd0: begin op_a = WORD_W'(r_pairs);  op_b = WORD_W'(r_sum_xy); end
            3'd1: begin op_a = WORD_W'(r_sum_x);  op_b = WORD_W'(r_sum_y);  end
            3'd2: begin op_a = WORD_W'(r_pairs);  op_b = WORD_W'(r_sum_xx); end
            3'd3: begin op_a = WORD_W'(r_sum_x);  op_b = WORD_W'(r_sum_x);  end
            3'd4: begin op_a = WORD_W'(r_pairs);  op_b = WORD_W'(r_sum_yy); end
            3'd5: begin op_a = WORD_W'(r_sum_y);  op_b = WORD_W'(r_sum_y);  end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ACC: begin
                case (r_c)
                    2'd0:    begin mul_a = MUL_W'(r_xa); mul_b = MUL_W'(r_ya); end
                    2'd1:    begin mul_a = MUL_W'(r_xa); mul_b = MUL_W'(r_xa); end
                    default: begin mul_a = MUL_W'(r_ya); mul_b = MUL_W'(r_ya); end
                endcase
            end
            S_PROD: begin
                // low 64 bits only: lo*lo + (lo*hi + hi*lo) << 32
                case (r_c)
                    2'd0:    begin mul_a = op_a[MUL_W-1:0];      mul_b = op_b[MUL_W-1:0]; end
                    2'd1:    begin mul_a = op_a[MUL_W-1:0];      mul_b = op_b[WORD_W-1:MUL_W]; end
                    default: begin mul_a = op_a[WORD_W-1:MUL_W]; mul_b = op_b[MUL_W-1:0]; end
                endcase
            end
            S_DMUL: begin
                mul_a = r_sx;
                mul_b = r_sy;
            end
            default: ;
        endcase
    end

    pcorr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign pp        = mul_p[SUMP_W-1:0];
    assign prod_full = r_acc + (mul_p << MUL_W);

    // ------------------------------------------------------------------
    // Shared compare / subtract: root steps and divide steps
    // ------------------------------------------------------------------
    logic [WORD_W:0]   su_a, su_b;
    logic [WORD_W+1:0] su_diff;
    logic              su_ge;
    logic [WORD_W-1:0] n_res;

    always_comb begin
        case (r_state)
            S_SQRT: begin
                su_a = {1'b0, r_v};
                su_b = {1'b0, r_res + r_bit};
            end
            S_DIV: begin
                su_a = {r_rem, r_nbits[DIV_STEPS-1]};
                su_b = {1'b0, r_d};
            end
            default: begin
                su_a = '0;
                su_b = '0;
            end
        endcase
    end

    assign su_diff = {1'b0, su_a} - {1'b0, su_b};
    assign su_ge   = !su_diff[WORD_W+1];
    assign n_res   = su_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // ------------------------------------------------------------------
    // Result rounding: round half up, clamp to +1.0, apply sign
    // ------------------------------------------------------------------
    logic [DIV_STEPS-1:0] q_rnd;
    logic [COEF_W-1:0]    q_mag;
    logic signed [COEF_W-1:0] coef_calc;
    logic                 zero_var;
    logic                 out_load;

    assign q_rnd     = (r_q >> 1) + DIV_STEPS'(r_q[0]);
    assign q_mag     = (q_rnd > DIV_STEPS'(Q_ONE)) ? COEF_W'(Q_ONE) : COEF_W'(q_rnd);
    assign coef_calc = r_zero ? '0 : (r_neg ? COEF_W'(-q_mag) : COEF_W'(q_mag));
    assign zero_var  = (r_vx == '0) || (r_vy == '0) || r_vx[WORD_W-1] || r_vy[WORD_W-1];

    // result moves into the output register once that register is empty or its result is taken
    assign out_load  = (r_state == S_OUT) && (!r_o_valid || !i_stall);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_xy  <= '0;
            r_sum_xx  <= '0;
            r_sum_yy  <= '0;
            r_pairs   <= '0;
            r_over    <= 1'b0;
            r_c       <= '0;
            r_j       <= '0;
            r_cnt     <= '0;
            r_sel_y   <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_last   <= i_last_pair;
                        r_xa     <= x_abs;
                        r_ya     <= y_abs;
                        r_neg_xy <= i_x_sample[SAMPLE_BITS-1] ^ i_y_sample[SAMPLE_BITS-1];
                        r_c      <= '0;
                        r_j      <= '0;
                        if (r_pairs >= PAIRS_W'(MAX_PAIRS)) begin
                            // set too long: pair dropped
                            r_over  <= 1'b1;
                            r_state <= i_last_pair ? S_PROD : S_IDLE;
                        end else begin
                            r_sum_x <= r_sum_x + SUMX_W'(i_x_sample);
                            r_sum_y <= r_sum_y + SUMX_W'(i_y_sample);
                            r_pairs <= r_pairs + 1'b1;
                            r_state <= S_ACC;
                        end
                    end
                end

                S_ACC: begin
                    r_c <= r_c + 1'b1;
                    case (r_c)
                        2'd1: r_sum_xy <= r_sum_xy + (r_neg_xy ? -pp : pp);
                        2'd2: r_sum_xx <= r_sum_xx + pp;
                        2'd3: begin
                            r_sum_yy <= r_sum_yy + pp;
                            r_state  <= r_last ? S_PROD : S_IDLE;
                        end
                        default: ;
                    endcase
                end

                S_PROD: begin
                    r_c <= r_c + 1'b1;
                    case (r_c)
                        2'd1: r_acc <= mul_p;
                        2'd2: r_acc <= prod_full;
                        2'd3: begin
                            r_j <= r_j + 1'b1;
                            if (!r_j[0]) begin
                                r_t <= prod_full;
                            end else begin
                                case (r_j[2:1])
                                    2'd0:    r_num <= r_t - prod_full;
                                    2'd1:    r_vx  <= r_t - prod_full;
                                    default: r_vy  <= r_t - prod_full;
                                endcase
                            end
                            if (r_j == 3'd5) begin
                                r_state <= S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end

                S_CHECK: begin
                    r_zero  <= zero_var;
                    r_neg   <= r_num[WORD_W-1];
                    r_mag   <= r_num[WORD_W-1] ? -r_num : r_num;
                    r_v     <= r_vx;
                    r_sel_y <= 1'b0;
                    r_state <= zero_var ? S_OUT : S_NORM;
                end

                S_NORM: begin
                    if (r_v[WORD_W-1:NORM_TOP] == '0) begin
                        // root grows one bit per two-bit shift of v, mag
                        // follows with one, so no shift count is kept
                        r_v   <= r_v << 2;
                        r_mag <= r_mag << 1;
                    end else begin
                        r_res   <= '0;
                        r_bit   <= WORD_W'(1) << (WORD_W - 2);
                        r_state <= S_SQRT;
                    end
                end

                S_SQRT: begin
                    if (r_bit[0] && !r_sel_y) begin
                        r_v <= r_vy;
                    end else if (su_ge) begin
                        r_v <= su_diff[WORD_W-1:0];
                    end
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        if (!r_sel_y) begin
                            r_sx    <= n_res[MUL_W-1:0];
                            r_sel_y <= 1'b1;
                            r_state <= S_NORM;
                        end else begin
                            r_sy    <= n_res[MUL_W-1:0];
                            r_c     <= '0;
                            r_state <= S_DMUL;
                        end
                    end
                end

                S_DMUL: begin
                    r_c <= r_c + 1'b1;
                    if (r_c == 2'd1) begin
                        r_d     <= mul_p;
                        r_rem   <= r_mag >> INT_BITS;
                        r_nbits <= {r_mag[INT_BITS-1:0], FRAC_BITS'(0)};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_rem   <= su_ge ? su_diff[WORD_W-1:0] : su_a[WORD_W-1:0];
                    r_q     <= {r_q[DIV_STEPS-2:0], su_ge};
                    r_nbits <= r_nbits << 1;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (out_load) begin
                        r_coef    <= coef_calc;
                        r_status  <= r_over ? ST_OVERFLOW :
                                     (r_zero ? ST_ZERO_VAR : ST_OK);
                        r_count   <= COUNT_W'(r_pairs);
                        r_sum_x   <= '0;
                        r_sum_y   <= '0;
                        r_sum_xy  <= '0;
                        r_sum_xx  <= '0;
                        r_sum_yy  <= '0;
                        r_pairs   <= '0;
                        r_over    <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_coefficient = r_coef;
    assign o_status      = r_status;
    assign o_pair_count  = r_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pairs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairs <= PAIRS_W'(MAX_PAIRS))
        else $error("pair count past limit");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_bit))
        else $error("root step bit not one-hot");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_d && r_d[WORD_W-1:NORM_TOP] != '0))
        else $error("divide remainder not below divisor");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coefficient <= 16'sd16384 && o_coefficient >= -16'sd16384))
        else $error("coefficient out of range");

    a_zero_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ZERO_VAR) |-> (o_coefficient == '0))
        else $error("zero variance with nonzero coefficient");

endmodule
